[sv/swpr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package swpr_pkg;

  // Default ring depth
  localparam int unsigned RING_DEPTH_DEF = 1024;

  // Field widths
  localparam int unsigned TIME_W  = 24;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned CFG_IDX_W = 1;

  // Largest ring depth for which the checker's output assertions are enabled
  localparam int unsigned MAX_COUNT = 1024;

  // Register reset values
  localparam logic [CFG_W-1:0] WIN_RESET = 16'd1000;
  localparam logic [CFG_W-1:0] CAP_RESET = 16'd1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAP    = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FULL_CHK,
    ST_PUSH,
    ST_POP_WAIT,
    ST_POP_CHK,
    ST_PEAK,
    ST_DIV,
    ST_DONE
  } swpr_state_e;

  // Divider status toward the sequencer
  typedef struct packed {
    logic done;
    logic rem_nonzero;
  } swpr_div_stat_t;

endpackage

`default_nettype wire

[sv/swpr_divider.sv]
`timescale 1ns / 1ps
`default_nettype none

module swpr_divider #(
  parameter int unsigned W = 11
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [W-1:0]              dividend_i,
  input  wire logic [swpr_pkg::CFG_W-1:0] divisor_i,
  output swpr_pkg::swpr_div_stat_t       stat_o,
  output logic      [W-1:0]              quotient_o
);
  import swpr_pkg::*;

  localparam int unsigned CNT_W = $clog2(W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]     quo_q, quo_d;
  logic [CFG_W-1:0] rem_q, rem_d;

  logic [CFG_W:0]   shifted;
  logic [CFG_W:0]   diff;
  logic             fits;

  // One restoring step: shift in next dividend bit, trial subtract
  always_comb begin
    shifted = {rem_q, quo_q[W-1]};
    diff    = shifted - {1'b0, divisor_i};
    fits    = (shifted >= {1'b0, divisor_i});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(W);
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[W-2:0], fits};
      rem_d = fits ? diff[CFG_W-1:0] : shifted[CFG_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign quotient_o         = quo_q;
  assign stat_o.done        = done_q;
  assign stat_o.rem_nonzero = (rem_q != '0);

endmodule

`default_nettype wire

[sv/sliding_window_peak_rate.sv]
`timescale 1ns / 1ps
`default_nettype none

// Sliding-window event-rate peak detector. Each input transaction carries a
// nondecreasing event timestamp; the block stores it in a ring, drops every
// oldest entry whose age is at least window_length, and returns one output
// transaction with the count now in the window, the running peak since the
// set began, ceil(peak / capacity_per_server) and a sticky overflow flag
// (ring full while its oldest entry was still in the window). first_of_set
// clears ring, peak and overflow before the event is taken. A zero
// window_length or capacity_per_server acts as 1. Configuration writes are
// taken at any cycle but should only be issued while the block is idle.
// Rate: one item at a time; an item passes through load, full check, push,
// then a pop wait and pop check, repeated while the oldest entry has aged
// out of the window (one pop at a time through the single ring read port),
// then the peak update and the bit-per-cycle divider, whose width is the
// count width (11 for a 1024-entry ring). An output stall holds the result
// in the done state. The next input is taken in the idle state that follows
// loading of the result, and pops amortize to one per event.
// The ring needs no clearing pass after reset.
module sliding_window_peak_rate #(
  parameter int unsigned RING_DEPTH = swpr_pkg::RING_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [swpr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [swpr_pkg::CFG_W-1:0]     cfg_wdata_i,
  // Input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [swpr_pkg::TIME_W-1:0]    event_time_i,
  input  wire logic                          first_of_set_i,
  // Output channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [swpr_pkg::COUNT_W-1:0]   window_count_o,
  output logic      [swpr_pkg::COUNT_W-1:0]   peak_count_o,
  output logic      [swpr_pkg::COUNT_W-1:0]   servers_needed_o,
  output logic                               overflow_o
);
  import swpr_pkg::*;

  localparam int unsigned IDX_W = $clog2(RING_DEPTH);
  localparam int unsigned OCC_W = $clog2(RING_DEPTH + 1);

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(RING_DEPTH - 1);
  localparam logic [OCC_W-1:0] FULL_OCC  = OCC_W'(RING_DEPTH);
  localparam logic [OCC_W:0]   DEPTH_SUM = (OCC_W + 1)'(RING_DEPTH);

  swpr_state_e state_q, state_d;

  // Configuration registers
  logic [CFG_W-1:0] win_q, cap_q;
  logic [CFG_W-1:0] win_eff, cap_eff;

  // Window state
  logic [IDX_W-1:0] head_q, head_d;
  logic [OCC_W-1:0] occ_q, occ_d;
  logic [OCC_W-1:0] peak_q, peak_d;
  logic             ovf_q, ovf_d;
  logic [TIME_W-1:0] time_q, time_d;

  // Ring memory, one write and one registered read port
  logic [TIME_W-1:0] ring_mem [RING_DEPTH];
  logic [TIME_W-1:0] rdata_q;
  logic              mem_we;
  logic [IDX_W-1:0]  tail_idx;
  logic [OCC_W:0]    tail_sum;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic               out_load;
  logic [COUNT_W-1:0] wcnt_q, pcnt_q, srv_q;
  logic               ovf_out_q;

  // Divider
  logic              div_start;
  swpr_div_stat_t    div_stat;
  logic [OCC_W-1:0]  div_quo;
  logic [OCC_W-1:0]  servers;

  logic              in_accept;
  logic [TIME_W-1:0] age;
  logic              in_window;
  logic [IDX_W-1:0]  head_next;

  assign win_eff = (win_q == '0) ? CFG_W'(1) : win_q;
  assign cap_eff = (cap_q == '0) ? CFG_W'(1) : cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WIN_RESET;
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IDX_WINDOW: win_q <= cfg_wdata_i;
        CFG_IDX_CAP:    cap_q <= cfg_wdata_i;
        default:        ;
      endcase
    end
  end

  assign in_accept = in_valid_i && !in_stall_o;

  // Age of the oldest entry against the current event, 24-bit wrapping
  assign age       = time_q - rdata_q;
  assign in_window = (age < {{(TIME_W - CFG_W){1'b0}}, win_eff});
  assign head_next = (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);

  // Tail = (head + occupancy) mod depth; the sum stays below twice the depth
  always_comb begin
    tail_sum = {1'b0, {(OCC_W - IDX_W){1'b0}}, head_q} + {1'b0, occ_q};
    if (tail_sum >= DEPTH_SUM) begin
      tail_sum = tail_sum - DEPTH_SUM;
    end
    tail_idx = tail_sum[IDX_W-1:0];
  end

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_accept) state_d = ST_LOAD;
      ST_LOAD:     state_d = ST_FULL_CHK;
      ST_FULL_CHK: state_d = ST_PUSH;
      ST_PUSH:     state_d = ST_POP_WAIT;
      ST_POP_WAIT: state_d = ST_POP_CHK;
      ST_POP_CHK: begin
        if (occ_q > OCC_W'(1) && !in_window) begin
          state_d = ST_POP_WAIT;
        end else begin
          state_d = ST_PEAK;
        end
      end
      ST_PEAK:     state_d = ST_DIV;
      ST_DIV:      if (div_stat.done) state_d = ST_DONE;
      ST_DONE:     if (out_load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    mem_we     = (state_q == ST_PUSH);
    div_start  = (state_q == ST_PEAK);
  end

  // Window datapath
  always_comb begin
    head_d = head_q;
    occ_d  = occ_q;
    peak_d = peak_q;
    ovf_d  = ovf_q;
    time_d = time_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          time_d = event_time_i;
          // Start a new set: clear window, peak and overflow
          if (first_of_set_i) begin
            head_d = '0;
            occ_d  = '0;
            peak_d = '0;
            ovf_d  = 1'b0;
          end
        end
      end
      ST_FULL_CHK: begin
        // Full ring: drop the oldest, flag it if still inside the window
        if (occ_q == FULL_OCC) begin
          if (in_window) begin
            ovf_d = 1'b1;
          end
          head_d = head_next;
          occ_d  = occ_q - OCC_W'(1);
        end
      end
      ST_PUSH: begin
        occ_d = occ_q + OCC_W'(1);
      end
      ST_POP_CHK: begin
        // Age out the oldest; the newest entry always stays
        if (occ_q > OCC_W'(1) && !in_window) begin
          head_d = head_next;
          occ_d  = occ_q - OCC_W'(1);
        end
      end
      ST_PEAK: begin
        if (occ_q > peak_q) begin
          peak_d = occ_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      occ_q   <= '0;
      peak_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      occ_q   <= occ_d;
      peak_q  <= peak_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;
  end

  // Ring: read the head entry every cycle, write the tail on push
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[tail_idx] <= time_q;
    end
    rdata_q <= ring_mem[head_q];
  end

  // Divide the peak as updated in this cycle
  swpr_divider #(
    .W (OCC_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (peak_d),
    .divisor_i  (cap_eff),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  // Round up: add one when the division leaves a remainder
  assign servers = div_quo + OCC_W'(div_stat.rem_nonzero);

  // Output register: hold the result until the transaction completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      wcnt_q    <= COUNT_W'(occ_q);
      pcnt_q    <= COUNT_W'(peak_q);
      srv_q     <= COUNT_W'(servers);
      ovf_out_q <= ovf_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign window_count_o   = wcnt_q;
  assign peak_count_o     = pcnt_q;
  assign servers_needed_o = srv_q;
  assign overflow_o       = ovf_out_q;

endmodule

`default_nettype wire

[sv/swpr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module swpr_checker #(
  parameter int unsigned RING_DEPTH = swpr_pkg::RING_DEPTH_DEF
) (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [swpr_pkg::COUNT_W-1:0] window_count_o,
  input wire logic [swpr_pkg::COUNT_W-1:0] peak_count_o,
  input wire logic [swpr_pkg::COUNT_W-1:0] servers_needed_o
);
  import swpr_pkg::*;

  // A result waiting on a stall stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // One item at a time: busy right after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in progress");

  if (RING_DEPTH <= MAX_COUNT) begin : g_unmasked
    a_count_le_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> window_count_o <= peak_count_o && window_count_o != '0)
      else $error("window count above peak or zero");

    a_servers_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> servers_needed_o != '0 && servers_needed_o <= peak_count_o)
      else $error("servers needed out of range");
  end

endmodule

bind sliding_window_peak_rate swpr_checker #(
  .RING_DEPTH (RING_DEPTH)
) u_swpr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .window_count_o   (window_count_o),
  .peak_count_o     (peak_count_o),
  .servers_needed_o (servers_needed_o)
);

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

  import swpr_pkg::*;

  localparam int unsigned RING = RING_DEPTH_DEF;

  // One output transaction of the block, field by field
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] peak;
    logic [COUNT_W-1:0] servers;
    logic               overflow;
  } peak_result_t;

  // Tracks the event window, the running peak and the sticky overflow, and
  // holds the results still owed by the block, oldest first.
  class window_peak_scoreboard;
    logic [TIME_W-1:0] stamps [RING];
    int unsigned       head;
    int unsigned       occupancy;
    int unsigned       peak;
    logic              sticky_ovf;
    logic [CFG_W-1:0]  window_reg;
    logic [CFG_W-1:0]  capacity_reg;
    peak_result_t      owed_results [$];
    int                errors;
    int                compared;
    int                overflow_hits;
    int unsigned       top_peak;

    function new();
      head          = 0;
      occupancy     = 0;
      peak          = 0;
      sticky_ovf    = 1'b0;
      window_reg    = WIN_RESET;
      capacity_reg  = CAP_RESET;
      errors        = 0;
      compared      = 0;
      overflow_hits = 0;
      top_peak      = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
      if (index == CFG_IDX_WINDOW) window_reg = value;
      else if (index == CFG_IDX_CAP) capacity_reg = value;
    endfunction

    // A zero window behaves as a window of one
    function int unsigned span();
      return (window_reg == '0) ? 1 : window_reg;
    endfunction

    function void take_event(logic [TIME_W-1:0] stamp, logic first);
      int unsigned       win;
      int unsigned       cap;
      int unsigned       tail;
      logic [TIME_W-1:0] age;
      peak_result_t      want;
      win = span();
      cap = (capacity_reg == '0) ? 1 : capacity_reg;
      if (first) begin
        head       = 0;
        occupancy  = 0;
        peak       = 0;
        sticky_ovf = 1'b0;
      end
      // Full ring: drop the oldest; flag it only if it was still in the window
      if (occupancy >= RING) begin
        age = stamp - stamps[head];
        if (age < win) sticky_ovf = 1'b1;
        head      = (head + 1) % RING;
        occupancy = occupancy - 1;
      end
      tail         = (head + occupancy) % RING;
      stamps[tail] = stamp;
      occupancy    = occupancy + 1;
      // Age out, wrapping difference; the newest entry always stays
      while (occupancy > 1) begin
        age = stamp - stamps[head];
        if (age < win) break;
        head      = (head + 1) % RING;
        occupancy = occupancy - 1;
      end
      if (occupancy > peak) peak = occupancy;
      want.count    = COUNT_W'(occupancy);
      want.peak     = COUNT_W'(peak);
      want.servers  = COUNT_W'((peak + cap - 1) / cap);
      want.overflow = sticky_ovf;
      owed_results.insert(owed_results.size(), want);
      if (sticky_ovf) overflow_hits++;
      if (peak > top_peak) top_peak = peak;
    endfunction

    function void compare_result(peak_result_t got);
      peak_result_t want;
      if (owed_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with nothing owed: count %0d peak %0d servers %0d ovf %0d",
                   $realtime, got.count, got.peak, got.servers, got.overflow);
        return;
      end
      want = owed_results[0];
      owed_results.delete(0);
      compared++;
      if (got.count !== want.count || got.peak !== want.peak ||
          got.servers !== want.servers || got.overflow !== want.overflow) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result %0d: want count %0d peak %0d servers %0d ovf %0d, got %0d %0d %0d %0d",
                   $realtime, compared, want.count, want.peak, want.servers, want.overflow,
                   got.count, got.peak, got.servers, got.overflow);
      end
    endfunction
  endclass

  // Clock, reset and all block inputs start at known values
  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i    = CFG_IDX_WINDOW;
  logic [CFG_W-1:0]     cfg_wdata_i    = '0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic [TIME_W-1:0]    event_time_i   = '0;
  logic                 first_of_set_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic [COUNT_W-1:0]   window_count_o;
  logic [COUNT_W-1:0]   peak_count_o;
  logic [COUNT_W-1:0]   servers_needed_o;
  logic                 overflow_o;

  window_peak_scoreboard sb = new();

  // Handshake pressure, in percent per cycle; set per phase
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int events_sent   = 0;
  int reg_writes    = 0;

  sliding_window_peak_rate uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .event_time_i     (event_time_i),
    .first_of_set_i   (first_of_set_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .window_count_o   (window_count_o),
    .peak_count_o     (peak_count_o),
    .servers_needed_o (servers_needed_o),
    .overflow_o       (overflow_o)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: check every accepted result, then pick the stall for the next
  // cycle. Sampling right after the edge sees the values from before it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.compare_result({window_count_o, peak_count_o, servers_needed_o, overflow_o});
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Hang guard, far above the slowest legal run
  initial begin
    #20_000_000;
    $display("timeout with %0d results still owed", sb.owed_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // 0: no idling, 1: sender idles, 2: receiver stalls, 3: both, lightly
  task automatic set_pressure(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      1: begin
        send_idle_pct = 59;
        stall_pct     = 0;
      end
      2: begin
        send_idle_pct = 0;
        stall_pct     = 59;
      end
      default: begin
        send_idle_pct = 19;
        stall_pct     = 19;
      end
    endcase
  endtask

  // Offer one event transaction and hold it until the block takes it. Valid
  // stays high afterward so back-to-back events need no gap.
  task automatic send_event(input logic [TIME_W-1:0] stamp, input logic first);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    event_time_i   <= stamp;
    first_of_set_i <= first;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.take_event(stamp, first);
    events_sent++;
  endtask

  // Drop valid and hold off until every owed result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.owed_results.size() != 0) @(posedge clk_i);
  endtask

  // Write one register; only called with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_register(index, value);
    reg_writes++;
    @(posedge clk_i);
  endtask

  // Random event sets: mostly well-formed nondecreasing runs with steps scaled
  // to the window, plus backward steps, random jumps and stray set starts.
  task automatic run_random(input int total);
    int                left;
    int                len;
    int                roll;
    int unsigned       w;
    logic [TIME_W-1:0] stamp;
    logic              first;
    left = total;
    w    = sb.span();
    while (left > 0) begin
      roll = $urandom_range(99);
      if (roll < 70) len = $urandom_range(1, 12);
      else if (roll < 95) len = $urandom_range(13, 60);
      else len = $urandom_range(61, 150);
      if (len > left) len = left;
      left  = left - len;
      stamp = TIME_W'($urandom);
      // Now and then continue the previous set instead of starting fresh
      send_event(stamp, ($urandom_range(9) != 0));
      for (int i = 1; i < len; i++) begin
        roll = $urandom_range(99);
        if (roll < 5) stamp = stamp;
        else if (roll < 55) stamp = stamp + TIME_W'($urandom_range(0, w / 4 + 1));
        else if (roll < 85) stamp = stamp + TIME_W'($urandom_range(0, w));
        else if (roll < 93) stamp = stamp + TIME_W'($urandom_range(w, 2 * w));
        else if (roll < 97) stamp = stamp - TIME_W'($urandom_range(1, w));
        else stamp = TIME_W'($urandom);
        first = ($urandom_range(99) < 2);
        send_event(stamp, first);
        if ($urandom_range(299) == 0) drain_results();
      end
    end
  endtask

  initial begin
    logic [TIME_W-1:0] t0;
    logic [CFG_W-1:0]  cfg_win [8];
    logic [CFG_W-1:0]  cfg_cap [8];

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed events at the reset window of 1000 and capacity of 1
    set_pressure(0);
    send_event(24'd0, 1'b1);
    send_event(24'd0, 1'b0);            // equal timestamps stay together
    send_event(24'd999, 1'b0);          // age one short of the window: keep
    send_event(24'd1000, 1'b0);         // age equal to the window: drop
    send_event(24'd1999, 1'b0);
    send_event(24'hFFFFFF, 1'b1);       // top of the time range, new set
    send_event(24'd5, 1'b0);            // wraps past zero, still in window
    send_event(24'd3, 1'b0);            // slightly backward
    send_event(24'h800000, 1'b0);       // far jump flushes everything older
    send_event(24'd500, 1'b1);
    send_event(24'd600, 1'b0);
    send_event(24'd100, 1'b0);          // out of order: older entries leave
    send_event(24'h555555, 1'b0);
    send_event(24'hAAAAAA, 1'b1);       // set start mid-stream
    drain_results();

    // Zero window and zero capacity both behave as one
    write_reg(CFG_IDX_WINDOW, 16'd0);
    write_reg(CFG_IDX_CAP, 16'd0);
    send_event(24'hAAAAAA, 1'b1);
    send_event(24'hAAAAAA, 1'b0);
    send_event(24'hAAAAAA, 1'b0);
    send_event(24'hAAAAAB, 1'b0);
    drain_results();

    // Widest register values
    write_reg(CFG_IDX_WINDOW, 16'hFFFF);
    write_reg(CFG_IDX_CAP, 16'hFFFF);
    send_event(24'h555555, 1'b1);
    send_event(24'h555555 + 24'd65534, 1'b0);
    send_event(24'h555555 + 24'd65535, 1'b0);
    drain_results();

    // Rounding up of the server count
    write_reg(CFG_IDX_WINDOW, 16'd10);
    write_reg(CFG_IDX_CAP, 16'd2);
    send_event(24'd40, 1'b1);
    send_event(24'd45, 1'b0);
    send_event(24'd49, 1'b0);
    send_event(24'd50, 1'b0);
    drain_results();

    // Full ring: one entry at t0 and 1023 at t0+1 fill it. The next event
    // pushes out t0, already outside the window, so no overflow; the one
    // after that has to drop an entry still inside and sets overflow.
    write_reg(CFG_IDX_WINDOW, 16'd600);
    write_reg(CFG_IDX_CAP, 16'd7);
    set_pressure(3);
    t0 = 24'hFFFF00;
    send_event(t0, 1'b1);
    repeat (RING - 1) send_event(t0 + 24'd1, 1'b0);
    send_event(t0 + 24'd600, 1'b0);
    send_event(t0 + 24'd600, 1'b0);
    for (int i = 0; i < 4; i++) send_event(t0 + 24'd601 + TIME_W'(i), 1'b0);
    // Far jump: one event ages out every entry but the newest
    send_event(t0 + 24'd5000, 1'b0);
    drain_results();

    // Random sets under each handshake mode, two register settings per mode
    cfg_win = '{16'd1, 16'hFFFF, 16'd0, 16'd20, CFG_W'($urandom_range(1, 200)),
                16'd300, 16'd5000, CFG_W'($urandom)};
    cfg_cap = '{16'd1, 16'hFFFF, 16'd0, 16'd3, CFG_W'($urandom_range(1, 16)),
                16'd1024, 16'd7, CFG_W'($urandom)};
    for (int p = 0; p < 8; p++) begin
      set_pressure(p / 2);
      write_reg(CFG_IDX_WINDOW, cfg_win[p]);
      write_reg(CFG_IDX_CAP, cfg_cap[p]);
      run_random(115);
      drain_results();
    end

    // Let anything stray come out before the verdict
    repeat (40) @(posedge clk_i);
    if (sb.owed_results.size() != 0) begin
      sb.errors += sb.owed_results.size();
      $display("%0d results never arrived", sb.owed_results.size());
    end

    $display("%0d events, %0d register writes, four handshake modes; %0d results compared",
             events_sent, reg_writes, sb.compared);
    $display("highest peak %0d, %0d results with overflow set", sb.top_peak, sb.overflow_hits);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d errors", sb.errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
